### hw/rtl/tsch_pkg.sv
// shared constants, types and helpers of the task scheduler
package tsch_pkg;

    // sizes
    localparam int MAX_TASKS     = 16;
    localparam int TIME_BITS     = 16;
    localparam int SLOT_BITS     = $clog2(MAX_TASKS);
    localparam int CNT_BITS      = $clog2(MAX_TASKS + 1);
    localparam int POL_BITS      = 2;
    localparam int QUANT_BITS    = 16;
    localparam int TCNT_BITS     = 5;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int LIM_BITS      = (TCNT_BITS > CNT_BITS) ? TCNT_BITS : CNT_BITS;

    // scheduling policies
    localparam logic [POL_BITS-1:0] POL_FIFO = 2'd0;
    localparam logic [POL_BITS-1:0] POL_RR   = 2'd1;
    localparam logic [POL_BITS-1:0] POL_SJF  = 2'd2;
    localparam logic [POL_BITS-1:0] POL_PSJF = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUANTUM    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TASK_COUNT = 2'd2;

    // request types
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // register reset values
    localparam logic [POL_BITS-1:0]   POLICY_RST  = POL_FIFO;
    localparam logic [QUANT_BITS-1:0] QUANTUM_RST = 16'd500;
    localparam logic [TCNT_BITS-1:0]  TCOUNT_RST  = 5'd1;

    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [MAX_TASKS-1:0] flags_t;

    // outcome of one slot scan
    typedef struct packed {
        logic  best_vld;
        slot_t best_idx;
        time_t best_rem;
        time_t best_key;
        logic  arrived;
    } scan_res_t;

    // one slot event (arrival)
    typedef struct packed {
        logic  vld;
        slot_t idx;
    } slot_ev_t;

    // write into the ready/stamp memory
    typedef struct packed {
        logic  we;
        slot_t addr;
        time_t rt;
        time_t stamp;
    } stamp_wr_t;

    // slots allowed by the task count register
    function automatic cnt_t slot_limit(input logic [TCNT_BITS-1:0] tcnt);
        logic [LIM_BITS-1:0] t;
        logic [LIM_BITS-1:0] m;
        t = LIM_BITS'(tcnt);
        m = LIM_BITS'(MAX_TASKS);
        return (t > m) ? CNT_BITS'(MAX_TASKS) : CNT_BITS'(t);
    endfunction

endpackage

### hw/rtl/tsch_ram.sv
// generic single-port-write, registered-read memory
module tsch_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/tsch_scan.sv
// slot scan: arrivals, restamping and best-candidate search, one slot per cycle
module tsch_scan (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  tsch_pkg::cnt_t            n_slots,
    input  logic [tsch_pkg::POL_BITS-1:0] policy,
    input  tsch_pkg::time_t           now,
    input  logic                      restamp,
    input  tsch_pkg::slot_t           runner,
    input  tsch_pkg::flags_t          act_flags,
    input  tsch_pkg::flags_t          done_flags,
    output logic                      rd_en,
    output tsch_pkg::slot_t           rd_addr,
    input  tsch_pkg::time_t           rd_rt,
    input  tsch_pkg::time_t           rd_stamp,
    input  tsch_pkg::time_t           rd_rem,
    output tsch_pkg::stamp_wr_t       st_wr,
    output tsch_pkg::slot_ev_t        arrive,
    output logic                      done,
    output tsch_pkg::scan_res_t       res
);

    logic               busy_reg, busy_next;
    tsch_pkg::cnt_t     cnt_reg, cnt_next;
    logic               pv_reg, pv_next;
    tsch_pkg::slot_t    pidx_reg, pidx_next;
    tsch_pkg::scan_res_t res_reg, res_next;

    logic            arr_c;
    logic            act_c;
    logic            rest_c;
    tsch_pkg::time_t stamp_c;
    tsch_pkg::time_t key_c;

    // read issue and process stage
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        pv_next   = 1'b0;
        pidx_next = pidx_reg;
        res_next  = res_reg;
        rd_en     = 1'b0;
        rd_addr   = cnt_reg[tsch_pkg::SLOT_BITS-1:0];
        done      = 1'b0;

        // slot under processing, memory data arrived this cycle
        arr_c   = pv_reg && !done_flags[pidx_reg] && !act_flags[pidx_reg]
                  && (rd_rem != '0) && (rd_rt == now);
        act_c   = act_flags[pidx_reg] || arr_c;
        rest_c  = restamp && (pidx_reg == runner);
        stamp_c = (arr_c || rest_c) ? now : rd_stamp;
        key_c   = (policy == tsch_pkg::POL_RR) ? stamp_c : rd_rem;

        st_wr.we    = pv_reg && (arr_c || rest_c);
        st_wr.addr  = pidx_reg;
        st_wr.rt    = rd_rt;
        st_wr.stamp = now;
        arrive.vld  = arr_c;
        arrive.idx  = pidx_reg;

        if (pv_reg) begin
            if (arr_c) begin
                res_next.arrived = 1'b1;
            end
            // strict compare keeps the lowest slot on ties
            if (act_c && (!res_reg.best_vld ||
                          (policy != tsch_pkg::POL_FIFO && key_c < res_reg.best_key))) begin
                res_next.best_vld = 1'b1;
                res_next.best_idx = pidx_reg;
                res_next.best_rem = rd_rem;
                res_next.best_key = key_c;
            end
        end

        if (start) begin
            busy_next        = 1'b1;
            cnt_next         = '0;
            res_next         = '0;
        end else if (busy_reg) begin
            if (cnt_reg < n_slots) begin
                rd_en     = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                pv_next   = 1'b1;
                pidx_next = cnt_reg[tsch_pkg::SLOT_BITS-1:0];
            end else if (!pv_reg) begin
                done      = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    assign res = res_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            pv_reg   <= pv_next;
            cnt_reg  <= cnt_next;
        end
    end

    // candidate and slot index
    always_ff @(posedge aclk) begin
        pidx_reg <= pidx_next;
        res_reg  <= res_next;
    end

    // a stamp write never hits the slot being read in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_wr.we && rd_en) |-> (st_wr.addr != rd_addr))
        else $error("stamp write collides with scan read");

endmodule

### hw/rtl/task_scheduler_fifo_rr_sjf.sv
// task scheduler top level: control sequencer, flags, slot memories and result register
//
//  channel   | handshake            | beat contents
//  ----------+----------------------+------------------------------------------------
//  config    | cfg_wr_en            | cfg_index, cfg_wdata (policy, quantum, task count)
//  input     | s_valid / s_ready    | s_req_type, s_ready_time, s_exec_time
//  result    | m_valid / m_ready    | finished, running, all_done, tick_time
//
// a load beat writes its slot while the sequencer is idle; a tick beat goes through the
// scan, pick and finish states, or straight to finish once all slots are done; the scan
// reads one slot of the memories per cycle, over the slots in use.
// one beat is worked on at a time; s_ready is high while the sequencer is idle, also
// while a result still waits in the output register.
// reset is synchronous, active low; the slot memories need no clearing pass.
// a stalled result holds the sequencer before its next result write.
module task_scheduler_fifo_rr_sjf (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tsch_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tsch_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  tsch_pkg::time_t                    s_ready_time,
    input  tsch_pkg::time_t                    s_exec_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_finished_valid,
    output tsch_pkg::slot_t                    m_finished_slot,
    output logic                               m_running_valid,
    output tsch_pkg::slot_t                    m_running_slot,
    output logic                               m_all_done,
    output tsch_pkg::time_t                    m_tick_time
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    // configuration
    logic [tsch_pkg::POL_BITS-1:0]   policy_reg;
    logic [tsch_pkg::QUANT_BITS-1:0] quantum_reg;
    logic [tsch_pkg::TCNT_BITS-1:0]  tcount_reg;

    // scheduler state
    tsch_pkg::time_t  now_reg, now_next;
    logic             rv_reg, rv_next;
    tsch_pkg::slot_t  runner_reg, runner_next;
    tsch_pkg::time_t  rrem_reg, rrem_next;
    logic [tsch_pkg::QUANT_BITS-1:0] qc_reg, qc_next;
    tsch_pkg::cnt_t   retired_reg, retired_next;
    tsch_pkg::cnt_t   loaded_reg, loaded_next;
    tsch_pkg::flags_t act_reg, act_next;
    tsch_pkg::flags_t done_reg, done_next;
    logic             restamp_reg, restamp_next;

    // per-tick result
    logic             fin_vld_reg, fin_vld_next;
    tsch_pkg::slot_t  fin_slot_reg, fin_slot_next;
    logic             tdone_reg, tdone_next;
    tsch_pkg::time_t  ttime_reg, ttime_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic             mo_fin_vld_reg, mo_fin_vld_next;
    tsch_pkg::slot_t  mo_fin_slot_reg, mo_fin_slot_next;
    logic             mo_run_vld_reg, mo_run_vld_next;
    tsch_pkg::slot_t  mo_run_slot_reg, mo_run_slot_next;
    logic             mo_done_reg, mo_done_next;
    tsch_pkg::time_t  mo_time_reg, mo_time_next;

    // scan unit and memories
    logic                scan_start;
    logic                scan_done;
    logic                rd_en;
    tsch_pkg::slot_t     rd_addr;
    tsch_pkg::stamp_wr_t st_wr;
    tsch_pkg::slot_ev_t  arrive;
    tsch_pkg::scan_res_t sres;
    logic [2*tsch_pkg::TIME_BITS-1:0] st_rd_data;
    logic [2*tsch_pkg::TIME_BITS-1:0] st_wr_data;
    tsch_pkg::time_t     rem_rd_data;
    logic                st_we;
    tsch_pkg::slot_t     st_waddr;
    logic                rem_we;
    tsch_pkg::slot_t     rem_waddr;
    tsch_pkg::time_t     rem_wdata;

    // combinational helpers
    tsch_pkg::cnt_t  limit_c;
    tsch_pkg::cnt_t  n_c;
    tsch_pkg::cnt_t  ret_inc_c;
    logic            all_done0_c;
    logic            all_done1_c;
    logic            retire_c;
    logic            load_wr_c;
    logic            rem_dec_c;
    logic            sel_c;
    logic            hold_c;
    logic            tie_c;
    logic            chg_c;
    logic            rv_new_c;
    tsch_pkg::time_t cur_rem_c;
    logic [tsch_pkg::QUANT_BITS-1:0] qbase_c;
    logic [tsch_pkg::QUANT_BITS-1:0] qeff_c;
    logic [tsch_pkg::QUANT_BITS:0]   qsum_c;
    tsch_pkg::time_t exec_c;
    tsch_pkg::slot_t load_idx_c;

    assign limit_c     = tsch_pkg::slot_limit(tcount_reg);
    assign n_c         = (loaded_reg < limit_c) ? loaded_reg : limit_c;
    assign ret_inc_c   = retired_reg + 1'b1;
    assign all_done0_c = (n_c != '0) && (retired_reg >= n_c);
    assign retire_c    = rv_reg && (rrem_reg == '0) && !all_done0_c;
    assign all_done1_c = all_done0_c || (retire_c && (ret_inc_c >= n_c));
    assign load_idx_c  = loaded_reg[tsch_pkg::SLOT_BITS-1:0];
    assign exec_c      = (s_exec_time == '0) ? tsch_pkg::time_t'(1) : s_exec_time;
    assign load_wr_c   = (state_reg == ST_IDLE) && s_valid && (s_req_type == tsch_pkg::REQ_LOAD)
                         && (loaded_reg < limit_c);

    // selection after the scan
    assign sel_c     = ((policy_reg != tsch_pkg::POL_RR) && sres.arrived) || !rv_reg
                       || (qc_reg == '0);
    assign hold_c    = ((policy_reg == tsch_pkg::POL_FIFO) || (policy_reg == tsch_pkg::POL_SJF))
                       && rv_reg;
    assign tie_c     = ((policy_reg == tsch_pkg::POL_SJF) || (policy_reg == tsch_pkg::POL_PSJF))
                       && rv_reg && (sres.best_rem == rrem_reg);
    assign chg_c     = sel_c && sres.best_vld && !hold_c && !tie_c
                       && (!rv_reg || (sres.best_idx != runner_reg));
    assign rv_new_c  = rv_reg || chg_c;
    assign cur_rem_c = chg_c ? sres.best_rem : rrem_reg;
    assign rem_dec_c = rv_new_c && (cur_rem_c != '0);
    assign qbase_c   = chg_c ? '0 : qc_reg;
    assign qeff_c    = (quantum_reg == '0) ? tsch_pkg::QUANT_BITS'(1) : quantum_reg;
    assign qsum_c    = {1'b0, qbase_c} + 1'b1;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        now_next         = now_reg;
        rv_next          = rv_reg;
        runner_next      = runner_reg;
        rrem_next        = rrem_reg;
        qc_next          = qc_reg;
        retired_next     = retired_reg;
        loaded_next      = loaded_reg;
        act_next         = act_reg;
        done_next        = done_reg;
        restamp_next     = restamp_reg;
        fin_vld_next     = fin_vld_reg;
        fin_slot_next    = fin_slot_reg;
        tdone_next       = tdone_reg;
        ttime_next       = ttime_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        mo_fin_vld_next  = mo_fin_vld_reg;
        mo_fin_slot_next = mo_fin_slot_reg;
        mo_run_vld_next  = mo_run_vld_reg;
        mo_run_slot_next = mo_run_slot_reg;
        mo_done_next     = mo_done_reg;
        mo_time_next     = mo_time_reg;
        scan_start       = 1'b0;
        rem_we           = 1'b0;
        rem_waddr        = load_idx_c;
        rem_wdata        = exec_c;

        // arrivals found by the scan
        if (arrive.vld) begin
            act_next[arrive.idx] = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_req_type == tsch_pkg::REQ_LOAD) begin
                    // load beat: fill the next free slot
                    if (load_wr_c) begin
                        rem_we                = 1'b1;
                        act_next[load_idx_c]  = 1'b0;
                        done_next[load_idx_c] = 1'b0;
                        loaded_next           = loaded_reg + 1'b1;
                    end
                end else if (s_valid) begin
                    // tick beat: retire a runner out of work, then start a scan unless all slots are done
                    fin_vld_next  = retire_c;
                    fin_slot_next = retire_c ? runner_reg : '0;
                    tdone_next    = all_done1_c;
                    ttime_next    = now_reg;
                    restamp_next  = (policy_reg == tsch_pkg::POL_RR) && rv_reg && !retire_c
                                    && (qc_reg == '0);
                    if (retire_c) begin
                        done_next[runner_reg] = 1'b1;
                        act_next[runner_reg]  = 1'b0;
                        rv_next               = 1'b0;
                        retired_next          = ret_inc_c;
                    end
                    if (all_done1_c) begin
                        state_next = ST_FIN;
                    end else begin
                        scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                // switch, run one tick, advance time
                rv_next     = rv_new_c;
                runner_next = chg_c ? sres.best_idx : runner_reg;
                rrem_next   = rem_dec_c ? (cur_rem_c - 1'b1) : cur_rem_c;
                rem_we      = rem_dec_c;
                rem_waddr   = runner_next;
                rem_wdata   = cur_rem_c - 1'b1;
                if (now_reg != '1) begin
                    now_next = now_reg + 1'b1;
                end
                qc_next    = (qsum_c >= {1'b0, qeff_c}) ? '0 : qsum_c[tsch_pkg::QUANT_BITS-1:0];
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // result beat into the output register
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    mo_fin_vld_next  = fin_vld_reg;
                    mo_fin_slot_next = fin_slot_reg;
                    mo_run_vld_next  = !tdone_reg && rv_reg;
                    mo_run_slot_next = (!tdone_reg && rv_reg) ? runner_reg : '0;
                    mo_done_next     = tdone_reg;
                    mo_time_next     = ttime_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // stamp memory writes from loads and from the scan
    assign st_we      = load_wr_c || st_wr.we;
    assign st_waddr   = load_wr_c ? load_idx_c : st_wr.addr;
    assign st_wr_data = load_wr_c ? {s_ready_time, tsch_pkg::time_t'(0)}
                                  : {st_wr.rt, st_wr.stamp};

    // ready time and round-robin stamp per slot
    tsch_ram #(
        .DATA_W (2 * tsch_pkg::TIME_BITS),
        .DEPTH  (tsch_pkg::MAX_TASKS)
    ) u_stamp_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (st_rd_data)
    );

    // remaining run time per slot
    tsch_ram #(
        .DATA_W (tsch_pkg::TIME_BITS),
        .DEPTH  (tsch_pkg::MAX_TASKS)
    ) u_rem_ram (
        .aclk    (aclk),
        .wr_en   (rem_we),
        .wr_addr (rem_waddr),
        .wr_data (rem_wdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rem_rd_data)
    );

    tsch_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .n_slots    (n_c),
        .policy     (policy_reg),
        .now        (now_reg),
        .restamp    (restamp_reg),
        .runner     (runner_reg),
        .act_flags  (act_reg),
        .done_flags (done_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_rt      (st_rd_data[2*tsch_pkg::TIME_BITS-1:tsch_pkg::TIME_BITS]),
        .rd_stamp   (st_rd_data[tsch_pkg::TIME_BITS-1:0]),
        .rd_rem     (rem_rd_data),
        .st_wr      (st_wr),
        .arrive     (arrive),
        .done       (scan_done),
        .res        (sres)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg  <= tsch_pkg::POLICY_RST;
            quantum_reg <= tsch_pkg::QUANTUM_RST;
            tcount_reg  <= tsch_pkg::TCOUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tsch_pkg::CFG_POLICY:     policy_reg  <= cfg_wdata[tsch_pkg::POL_BITS-1:0];
                tsch_pkg::CFG_QUANTUM:    quantum_reg <= cfg_wdata[tsch_pkg::QUANT_BITS-1:0];
                tsch_pkg::CFG_TASK_COUNT: tcount_reg  <= cfg_wdata[tsch_pkg::TCNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            rv_reg      <= 1'b0;
            qc_reg      <= '0;
            retired_reg <= '0;
            loaded_reg  <= '0;
            act_reg     <= '0;
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            rv_reg      <= rv_next;
            qc_reg      <= qc_next;
            retired_reg <= retired_next;
            loaded_reg  <= loaded_next;
            act_reg     <= act_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        runner_reg      <= runner_next;
        rrem_reg        <= rrem_next;
        restamp_reg     <= restamp_next;
        fin_vld_reg     <= fin_vld_next;
        fin_slot_reg    <= fin_slot_next;
        tdone_reg       <= tdone_next;
        ttime_reg       <= ttime_next;
        mo_fin_vld_reg  <= mo_fin_vld_next;
        mo_fin_slot_reg <= mo_fin_slot_next;
        mo_run_vld_reg  <= mo_run_vld_next;
        mo_run_slot_reg <= mo_run_slot_next;
        mo_done_reg     <= mo_done_next;
        mo_time_reg     <= mo_time_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_finished_valid = mo_fin_vld_reg;
    assign m_finished_slot  = mo_fin_slot_reg;
    assign m_running_valid  = mo_run_vld_reg;
    assign m_running_slot   = mo_run_slot_reg;
    assign m_all_done       = mo_done_reg;
    assign m_tick_time      = mo_time_reg;

    // a retired slot is never active
    assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg & act_reg) == '0)
        else $error("slot both retired and active");

    // the runner is always an active slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        rv_reg |-> act_reg[runner_reg])
        else $error("runner slot not active");

    // retirements never outnumber loads
    assert property (@(posedge aclk) disable iff (!aresetn)
        retired_reg <= loaded_reg)
        else $error("retired count above loaded count");

endmodule
